// ===== hdl/particle_euler_integrator_assert.svh =====
// assertion macros for the particle integrator
// used by the top level; clk and rst_n must be in scope where a macro is used
`ifndef PARTICLE_EULER_INTEGRATOR_ASSERT_SVH
`define PARTICLE_EULER_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PEI_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pei check failed (same cycle)");
`define PEI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pei check failed (next cycle)");
`else
`define PEI_ASSERT_SAME(label, pre, post)
`define PEI_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/pei_pkg.sv =====
// shared types, constants and arithmetic helpers for the particle integrator
// no dependencies
`timescale 1ns / 1ps

package pei_pkg;

  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;
  localparam int Q_W         = 32;
  localparam int DT_W        = 16;
  localparam int IMASS_W     = 31;
  localparam int DAMP_W      = 17;
  localparam int CFG_DATA_W  = 31;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 66;
  localparam int ROOT_W      = 64;
  localparam int Y_W         = 31;
  localparam int ROOT_CNT_W  = 4;
  localparam int ROOT_CYCLES = 16;

  localparam logic signed [PROD_W-1:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] Q_MIN_W = -66'sd2147483648;

  typedef enum logic [2:0] {
    CMD_ADD_FORCE = 3'd0,
    CMD_SET_ACC   = 3'd1,
    CMD_SET_POS   = 3'd2,
    CMD_SET_VEL   = 3'd3,
    CMD_INTEGRATE = 3'd4
  } cmd_t;

  typedef enum logic {
    CFG_INV_MASS = 1'b0,
    CFG_DAMPING  = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PLAIN, OP_POW_INIT, OP_LOG_MUL, OP_LOG_UPD, OP_E_MUL,
    OP_EXP_INIT, OP_ROOT_INIT, OP_ROOT_STEP, OP_ROOT_DONE, OP_P_DONE,
    OP_MUL_POS, OP_WB_POS, OP_MUL_ACC, OP_WB_ACC, OP_MUL_VEL, OP_WB_VEL,
    OP_MUL_DAMP, OP_WB_DAMP, OP_FINISH, OP_PUBLISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOG_MUL, S_LOG_UPD, S_E_MUL, S_EXP_INIT,
    S_ROOT_INIT, S_ROOT_STEP, S_ROOT_DONE, S_P_DONE,
    S_MUL_POS, S_WB_POS, S_MUL_ACC, S_WB_ACC, S_MUL_VEL, S_WB_VEL,
    S_MUL_DAMP, S_WB_DAMP, S_FINISH, S_PUBLISH
  } state_t;

  typedef struct packed {
    dp_op_t              op;
    logic [AXIS_W-1:0]   axis;
  } dp_cmd_t;

  typedef struct packed {
    logic integrate;
    logic skip;
    logic pow_trivial;
  } dp_status_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
    logic [ROOT_W-1:0] one;
  } root_t;

  // clip to 32 bits, msb of the result flags a clip
  function automatic logic [Q_W:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic [Q_W:0] res;
    if (v > Q_MAX_W) begin
      res = {1'b1, 1'b0, {(Q_W-1){1'b1}}};
    end else if (v < Q_MIN_W) begin
      res = {1'b1, 1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = {1'b0, v[Q_W-1:0]};
    end
    return res;
  endfunction

  // one restoring square root digit
  function automatic root_t root_step(input root_t a);
    root_t             b;
    logic [ROOT_W-1:0] trial;
    b     = a;
    trial = a.res + a.one;
    if (a.rem >= trial) begin
      b.rem = a.rem - trial;
      b.res = (a.res >> 1) + a.one;
    end else begin
      b.res = a.res >> 1;
    end
    b.one = a.one >> 2;
    return b;
  endfunction

endpackage

// ===== hdl/pei_dp.sv =====
// datapath: particle state, config registers, shared multiplier, power unit
// depends on pei_pkg; driven by pei_ctrl commands
`timescale 1ns / 1ps

module pei_dp import pei_pkg::*; #(
  parameter int FRAC_BITS      = 16,
  parameter int POW_ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2:0]                         in_cmd,
  input  logic signed [Q_W-1:0]              in_vec_x,
  input  logic signed [Q_W-1:0]              in_vec_y,
  input  logic signed [Q_W-1:0]              in_vec_z,
  input  logic [DT_W-1:0]                    in_step_time,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  input  dp_cmd_t                            cmd,
  output dp_status_t                         status,
  output logic [NUM_AXES-1:0][Q_W-1:0]       out_pos,
  output logic [NUM_AXES-1:0][Q_W-1:0]       out_vel,
  output logic [NUM_AXES-1:0][Q_W-1:0]       out_acc,
  output logic                               out_sat
);

  localparam int LQ_W = POW_ITERATIONS + 5;
  localparam int IP_W = 5;
  localparam logic [IMASS_W-1:0] IMASS_RST = IMASS_W'(64'd1 << FRAC_BITS);

  // architectural state
  logic [NUM_AXES-1:0][Q_W-1:0] pos_r, vel_r, acc_r, frc_r;
  logic                         ovr_r, sat_r;
  logic [IMASS_W-1:0]           imass_r;
  logic [DAMP_W-1:0]            damp_r;

  // item and scratch registers
  logic [2:0]                   cmd_r;
  logic [NUM_AXES-1:0][Q_W-1:0] vec_r;
  logic [DT_W-1:0]              dt_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic [Y_W-1:0]               x_r;
  logic [POW_ITERATIONS-1:0]    frac_r, f_r;
  logic [3:0]                   s_r;
  logic [IP_W-1:0]              ip_r;
  logic [Y_W-1:0]               y_r;
  root_t                        root_r;
  logic [DAMP_W-1:0]            p_r;
  logic [Q_W-1:0]               vtmp_r;
  logic [NUM_AXES-1:0][Q_W-1:0] opos_r, ovel_r, oacc_r;
  logic                         osat_r;

  logic [3:0]                   s_c;
  logic [15:0]                  m_c;
  logic [LQ_W-1:0]              lq_c;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod_c, shr16_c;
  logic [AXIS_W-1:0]            ax;
  logic [Q_W:0]                 pos_sat_c, acc_sat_c, v_sat_c;
  logic [NUM_AXES-1:0][Q_W:0]   fsum_c;
  logic [Q_W-1:0]               sq_c;
  logic [Y_W-1:0]               yh_c;

  assign ax = cmd.axis;

  assign status.integrate   = (cmd_t'(cmd_r) == CMD_INTEGRATE);
  assign status.skip        = (dt_r == '0) || (imass_r == '0);
  assign status.pow_trivial = damp_r[DAMP_W-1] || (damp_r == '0);

  // normalizing shift: highest set bit of damping wins
  always_comb begin
    s_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (damp_r[i]) s_c = 4'(15 - i);
    end
  end
  assign m_c  = damp_r[15:0] << s_c;
  assign lq_c = ((LQ_W'(s_r) + LQ_W'(1)) << POW_ITERATIONS) - LQ_W'(frac_r);

  always_comb begin
    unique case (cmd.op)
      OP_LOG_MUL: begin
        mul_a = $signed({2'b00, x_r});
        mul_b = $signed({2'b00, x_r});
      end
      OP_E_MUL: begin
        mul_a = $signed(MUL_W'(lq_c));
        mul_b = $signed(MUL_W'(dt_r));
      end
      OP_MUL_POS: begin
        mul_a = MUL_W'($signed(vel_r[ax]));
        mul_b = $signed(MUL_W'(dt_r));
      end
      OP_MUL_ACC: begin
        mul_a = MUL_W'($signed(frc_r[ax]));
        mul_b = $signed(MUL_W'(imass_r));
      end
      OP_MUL_VEL: begin
        mul_a = MUL_W'($signed(acc_r[ax]));
        mul_b = $signed(MUL_W'(dt_r));
      end
      OP_MUL_DAMP: begin
        mul_a = MUL_W'($signed(vtmp_r));
        mul_b = $signed(MUL_W'(p_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_c  = mul_a * mul_b;
  assign shr16_c = prod_r >>> 16;

  assign pos_sat_c = sat_q(PROD_W'($signed(pos_r[ax])) + shr16_c);
  assign acc_sat_c = sat_q(prod_r >>> FRAC_BITS);
  assign v_sat_c   = sat_q(PROD_W'($signed(vel_r[ax])) + shr16_c);
  assign sq_c      = prod_r[61:30];
  assign yh_c      = f_r[0] ? (y_r >> 1) : y_r;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      fsum_c[i] = sat_q(PROD_W'($signed(frc_r[i])) + PROD_W'($signed(vec_r[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      vel_r   <= '0;
      acc_r   <= '0;
      frc_r   <= '0;
      ovr_r   <= 1'b0;
      sat_r   <= 1'b0;
      imass_r <= IMASS_RST;
      damp_r  <= DAMP_W'(65536);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_INV_MASS: imass_r <= cfg_data;
          CFG_DAMPING:  damp_r  <= cfg_data[DAMP_W-1:0];
        endcase
      end
      unique case (cmd.op)
        OP_LOAD: sat_r <= 1'b0;
        OP_PLAIN: begin
          unique case (cmd_r)
            CMD_ADD_FORCE: begin
              for (int i = 0; i < NUM_AXES; i++) frc_r[i] <= fsum_c[i][Q_W-1:0];
              sat_r <= fsum_c[0][Q_W] | fsum_c[1][Q_W] | fsum_c[2][Q_W];
            end
            CMD_SET_ACC: begin
              acc_r <= vec_r;
              ovr_r <= 1'b1;
            end
            CMD_SET_POS: pos_r <= vec_r;
            CMD_SET_VEL: vel_r <= vec_r;
            default: ;
          endcase
        end
        OP_WB_POS: begin
          pos_r[ax] <= pos_sat_c[Q_W-1:0];
          sat_r     <= sat_r | pos_sat_c[Q_W];
        end
        OP_WB_ACC: begin
          if (!ovr_r) begin
            acc_r[ax] <= acc_sat_c[Q_W-1:0];
            sat_r     <= sat_r | acc_sat_c[Q_W];
          end
        end
        OP_WB_VEL:  sat_r <= sat_r | v_sat_c[Q_W];
        OP_WB_DAMP: vel_r[ax] <= shr16_c[Q_W-1:0];
        OP_FINISH: begin
          frc_r <= '0;
          ovr_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r    <= in_cmd;
        vec_r[0] <= in_vec_x;
        vec_r[1] <= in_vec_y;
        vec_r[2] <= in_vec_z;
        dt_r     <= in_step_time;
      end
      OP_POW_INIT: begin
        s_r    <= s_c;
        x_r    <= {m_c, 15'b0};
        frac_r <= '0;
        p_r    <= damp_r[DAMP_W-1] ? DAMP_W'(65536) : '0;
      end
      OP_LOG_UPD: begin
        // square reached 2.0: halve and emit a one
        if (sq_c[Q_W-1]) begin
          x_r    <= sq_c[Q_W-1:1];
          frac_r <= {frac_r[POW_ITERATIONS-2:0], 1'b1};
        end else begin
          x_r    <= sq_c[Y_W-1:0];
          frac_r <= {frac_r[POW_ITERATIONS-2:0], 1'b0};
        end
      end
      OP_EXP_INIT: begin
        ip_r <= prod_r[POW_ITERATIONS+20:POW_ITERATIONS+16];
        f_r  <= prod_r[POW_ITERATIONS+15:16];
        y_r  <= Y_W'(64'd1 << 30);
      end
      OP_ROOT_INIT: begin
        root_r.rem <= ROOT_W'(yh_c) << 30;
        root_r.res <= '0;
        root_r.one <= ROOT_W'(64'd1 << 62);
        f_r        <= f_r >> 1;
      end
      OP_ROOT_STEP: root_r <= root_step(root_step(root_r));
      OP_ROOT_DONE: y_r <= root_r.res[Y_W-1:0];
      OP_P_DONE:    p_r <= DAMP_W'((y_r >> ip_r) >> 14);
      OP_WB_VEL:    vtmp_r <= v_sat_c[Q_W-1:0];
      OP_PUBLISH: begin
        opos_r <= pos_r;
        ovel_r <= vel_r;
        oacc_r <= acc_r;
        osat_r <= sat_r;
      end
      default: ;
    endcase
  end

  assign out_pos = opos_r;
  assign out_vel = ovel_r;
  assign out_acc = oacc_r;
  assign out_sat = osat_r;

endmodule

// ===== hdl/pei_ctrl.sv =====
// controller: sequences one item through the datapath and owns the handshakes
// depends on pei_pkg; drives pei_dp
`timescale 1ns / 1ps

module pei_ctrl import pei_pkg::*; #(
  parameter int POW_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(POW_ITERATIONS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POW_ITERATIONS - 1);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ROOT_CNT_W-1:0]   scnt_r, scnt_nxt;
  logic [AXIS_W-1:0]       axis_r, axis_nxt;
  logic                    out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scnt_r      <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scnt_r      <= scnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scnt_nxt      = scnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.axis      = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!status.integrate) begin
          cmd.op    = OP_PLAIN;
          state_nxt = S_PUBLISH;
        end else if (status.skip) begin
          state_nxt = S_PUBLISH;
        end else begin
          cmd.op   = OP_POW_INIT;
          cnt_nxt  = '0;
          axis_nxt = '0;
          state_nxt = status.pow_trivial ? S_MUL_POS : S_LOG_MUL;
        end
      end
      S_LOG_MUL: begin
        cmd.op    = OP_LOG_MUL;
        state_nxt = S_LOG_UPD;
      end
      S_LOG_UPD: begin
        cmd.op = OP_LOG_UPD;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_E_MUL;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_LOG_MUL;
        end
      end
      S_E_MUL: begin
        cmd.op    = OP_E_MUL;
        state_nxt = S_EXP_INIT;
      end
      S_EXP_INIT: begin
        cmd.op    = OP_EXP_INIT;
        state_nxt = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd.op    = OP_ROOT_INIT;
        scnt_nxt  = '0;
        state_nxt = S_ROOT_STEP;
      end
      S_ROOT_STEP: begin
        cmd.op   = OP_ROOT_STEP;
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == ROOT_CNT_W'(ROOT_CYCLES - 1)) state_nxt = S_ROOT_DONE;
      end
      S_ROOT_DONE: begin
        cmd.op = OP_ROOT_DONE;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_P_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_ROOT_INIT;
        end
      end
      S_P_DONE: begin
        cmd.op    = OP_P_DONE;
        axis_nxt  = '0;
        state_nxt = S_MUL_POS;
      end
      S_MUL_POS: begin
        cmd.op    = OP_MUL_POS;
        state_nxt = S_WB_POS;
      end
      S_WB_POS: begin
        cmd.op    = OP_WB_POS;
        state_nxt = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        cmd.op    = OP_MUL_ACC;
        state_nxt = S_WB_ACC;
      end
      S_WB_ACC: begin
        cmd.op    = OP_WB_ACC;
        state_nxt = S_MUL_VEL;
      end
      S_MUL_VEL: begin
        cmd.op    = OP_MUL_VEL;
        state_nxt = S_WB_VEL;
      end
      S_WB_VEL: begin
        cmd.op    = OP_WB_VEL;
        state_nxt = S_MUL_DAMP;
      end
      S_MUL_DAMP: begin
        cmd.op    = OP_MUL_DAMP;
        state_nxt = S_WB_DAMP;
      end
      S_WB_DAMP: begin
        cmd.op = OP_WB_DAMP;
        if (axis_r == AXIS_W'(NUM_AXES - 1)) begin
          axis_nxt  = '0;
          state_nxt = S_FINISH;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MUL_POS;
        end
      end
      S_FINISH: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_PUBLISH;
      end
      S_PUBLISH: begin
        // wait until the output register is free or being taken
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/particle_euler_integrator.sv =====
// top level of the particle integrator: ports, controller and datapath
// depends on pei_pkg, pei_ctrl, pei_dp and particle_euler_integrator_assert.svh
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_cmd, in_vec_x/y/z, in_step_time
//   out      out_valid/out_stall out_pos_*, out_vel_*, out_acc_*, out_saturated
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// plain commands and skipped steps go from accept through dispatch straight to publish;
// integrate also runs the log, exp and square-root steps of the damping power, except when
// damping is 0 or at least one; the square-root steps set its length (two root bits per
// cycle, one root per fraction bit of the exponent).
// rst_n is synchronous; it restores zero state, unit inverse mass, no damping.
// a new item is taken while the last result still waits in the output register;
// a stalled result holds the next item in its final cycle until it is taken.
`timescale 1ns / 1ps
`include "particle_euler_integrator_assert.svh"

module particle_euler_integrator import pei_pkg::*; #(
  parameter int FRAC_BITS      = 16,
  parameter int POW_ITERATIONS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_cmd,
  input  logic signed [Q_W-1:0]  in_vec_x,
  input  logic signed [Q_W-1:0]  in_vec_y,
  input  logic signed [Q_W-1:0]  in_vec_z,
  input  logic [DT_W-1:0]        in_step_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [Q_W-1:0]  out_pos_x,
  output logic signed [Q_W-1:0]  out_pos_y,
  output logic signed [Q_W-1:0]  out_pos_z,
  output logic signed [Q_W-1:0]  out_vel_x,
  output logic signed [Q_W-1:0]  out_vel_y,
  output logic signed [Q_W-1:0]  out_vel_z,
  output logic signed [Q_W-1:0]  out_acc_x,
  output logic signed [Q_W-1:0]  out_acc_y,
  output logic signed [Q_W-1:0]  out_acc_z,
  output logic                   out_saturated,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t                      dp_cmd;
  dp_status_t                   dp_status;
  logic [NUM_AXES-1:0][Q_W-1:0] pos_w, vel_w, acc_w;

  assign cfg_ready = 1'b1;

  pei_ctrl #(
    .POW_ITERATIONS (POW_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  pei_dp #(
    .FRAC_BITS      (FRAC_BITS),
    .POW_ITERATIONS (POW_ITERATIONS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_cmd),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .in_step_time (in_step_time),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .out_pos      (pos_w),
    .out_vel      (vel_w),
    .out_acc      (acc_w),
    .out_sat      (out_saturated)
  );

  assign out_pos_x = pos_w[0];
  assign out_pos_y = pos_w[1];
  assign out_pos_z = pos_w[2];
  assign out_vel_x = vel_w[0];
  assign out_vel_y = vel_w[1];
  assign out_vel_z = vel_w[2];
  assign out_acc_x = acc_w[0];
  assign out_acc_y = acc_w[1];
  assign out_acc_z = acc_w[2];

  // an accepted item keeps the block busy for at least the next cycle
  `PEI_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  // a new result only appears at the end of an item in flight
  `PEI_ASSERT_SAME(a_result_from_item, $rose(out_valid), $past(in_stall))
  // a result is never published over one that is still stalled
  `PEI_ASSERT_NEXT(a_no_overwrite, out_valid && out_stall && in_stall, out_valid)

endmodule

// ===== tb/particle_euler_integrator_checker.sv =====
// result checker for the particle integrator: watches the three channels,
// keeps its own copy of the particle state and compares every result
// depends on pei_pkg
`timescale 1ns / 1ps

module particle_euler_integrator_checker import pei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [2:0]            in_cmd,
  input  logic signed [Q_W-1:0] in_vec_x,
  input  logic signed [Q_W-1:0] in_vec_y,
  input  logic signed [Q_W-1:0] in_vec_z,
  input  logic [DT_W-1:0]       in_step_time,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic signed [Q_W-1:0] out_pos_x,
  input  logic signed [Q_W-1:0] out_pos_y,
  input  logic signed [Q_W-1:0] out_pos_z,
  input  logic signed [Q_W-1:0] out_vel_x,
  input  logic signed [Q_W-1:0] out_vel_y,
  input  logic signed [Q_W-1:0] out_vel_z,
  input  logic signed [Q_W-1:0] out_acc_x,
  input  logic signed [Q_W-1:0] out_acc_y,
  input  logic signed [Q_W-1:0] out_acc_z,
  input  logic                  out_saturated,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen,
  output int                    steps_seen
);

  localparam int FRAC = 16;
  localparam int POW_ITERS = 16;

  typedef struct packed {
    logic [2:0][Q_W-1:0] pos;
    logic [2:0][Q_W-1:0] vel;
    logic [2:0][Q_W-1:0] acc;
    logic                sat;
  } particle_state_t;

  particle_state_t expected_states[$];

  longint pos_q[3], vel_q[3], acc_q[3], force_q[3];
  bit     acc_locked;
  longint inv_mass;
  longint unsigned damp;

  function automatic longint clip_q(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, bt;
    int i;
    r = 0;
    bt = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // damping^dt in q1.16 via log2 by squaring and exp2 by repeated roots
  function automatic longint unsigned damp_power(input longint unsigned d,
                                                 input longint unsigned dt);
    longint unsigned x, frac, lq, e, ip, f, y;
    int s, i;
    if (d >= 65536) return 65536;
    if (d == 0) return 0;
    s = 0;
    frac = 0;
    while (((d << s) & 64'h8000) == 0 && s < 16) s++;
    x = (d << s) << 15;
    for (i = 0; i < POW_ITERS; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 64'd1;
      end
    end
    lq = ((longint'(s) + 1) << POW_ITERS) - frac;
    e = lq * dt;
    ip = e >> (POW_ITERS + 16);
    f = (e >> 16) & ((64'd1 << POW_ITERS) - 1);
    y = 64'd1 << 30;
    for (i = 0; i < POW_ITERS; i++) begin
      if (f[i]) y = y >> 1;
      y = root64(y << 30);
    end
    y = (ip >= 64) ? 64'd0 : (y >> ip);
    return y >> 14;
  endfunction

  task automatic advance_particle(input logic [2:0] c, input logic signed [Q_W-1:0] vx,
                                  input logic signed [Q_W-1:0] vy,
                                  input logic signed [Q_W-1:0] vz,
                                  input logic [DT_W-1:0] dt);
    longint vec[3];
    longint v, p, dtl;
    bit hit;
    int k;
    particle_state_t r;
    vec[0] = longint'(vx);
    vec[1] = longint'(vy);
    vec[2] = longint'(vz);
    dtl = longint'(dt);
    hit = 1'b0;
    case (c)
      CMD_ADD_FORCE: begin
        for (k = 0; k < 3; k++) force_q[k] = clip_q(force_q[k] + vec[k], hit);
      end
      CMD_SET_ACC: begin
        for (k = 0; k < 3; k++) acc_q[k] = vec[k];
        acc_locked = 1'b1;
      end
      CMD_SET_POS: begin
        for (k = 0; k < 3; k++) pos_q[k] = vec[k];
      end
      CMD_SET_VEL: begin
        for (k = 0; k < 3; k++) vel_q[k] = vec[k];
      end
      CMD_INTEGRATE: begin
        // zero step or immovable particle keeps everything, force and override too
        if (dt != 0 && inv_mass != 0) begin
          steps_seen++;
          p = longint'(damp_power(damp, longint'(dt)));
          for (k = 0; k < 3; k++) begin
            pos_q[k] = clip_q(pos_q[k] + ((vel_q[k] * dtl) >>> 16), hit);
            if (!acc_locked) acc_q[k] = clip_q((force_q[k] * inv_mass) >>> FRAC, hit);
            v = clip_q(vel_q[k] + ((acc_q[k] * dtl) >>> 16), hit);
            vel_q[k] = (v * p) >>> 16;
            force_q[k] = 0;
          end
          acc_locked = 1'b0;
        end
      end
      default: ;
    endcase
    for (k = 0; k < 3; k++) begin
      r.pos[k] = pos_q[k][Q_W-1:0];
      r.vel[k] = vel_q[k][Q_W-1:0];
      r.acc[k] = acc_q[k][Q_W-1:0];
    end
    r.sat = hit;
    expected_states.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [Q_W-1:0] exp_v,
                               input logic [Q_W-1:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    steps_seen = 0;
    for (int k = 0; k < 3; k++) begin
      pos_q[k] = 0;
      vel_q[k] = 0;
      acc_q[k] = 0;
      force_q[k] = 0;
    end
    acc_locked = 1'b0;
    inv_mass = 64'd1 << FRAC;
    damp = 65536;
  end

  assign pending = expected_states.size();

  always @(posedge clk) begin
    particle_state_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item outstanding, actual pos_x %h", $time,
                   out_pos_x);
        end else begin
          e = expected_states.pop_front();
          compare_field("pos_x", e.pos[0], out_pos_x);
          compare_field("pos_y", e.pos[1], out_pos_y);
          compare_field("pos_z", e.pos[2], out_pos_z);
          compare_field("vel_x", e.vel[0], out_vel_x);
          compare_field("vel_y", e.vel[1], out_vel_y);
          compare_field("vel_z", e.vel[2], out_vel_z);
          compare_field("acc_x", e.acc[0], out_acc_x);
          compare_field("acc_y", e.acc[1], out_acc_y);
          compare_field("acc_z", e.acc[2], out_acc_z);
          compare_field("saturated", {31'd0, e.sat}, {31'd0, out_saturated});
        end
      end
      if (in_valid && !in_stall) begin
        advance_particle(in_cmd, in_vec_x, in_vec_y, in_vec_z, in_step_time);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INV_MASS) inv_mass = longint'(cfg_data);
        else damp = longint'(cfg_data[DAMP_W-1:0]);
      end
    end
  end

endmodule

// ===== tb/particle_euler_integrator_tb.sv =====
// testbench top for the particle integrator: clock, reset, stimulus and verdict
// depends on pei_pkg, particle_euler_integrator and particle_euler_integrator_checker
`timescale 1ns / 1ps

module particle_euler_integrator_tb import pei_pkg::*; ;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            in_cmd;
  logic signed [Q_W-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic [DT_W-1:0]       in_step_time;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [Q_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [Q_W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic signed [Q_W-1:0] out_acc_x, out_acc_y, out_acc_z;
  logic                  out_saturated;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, results_seen, steps_seen;
  int send_idle_pct, recv_stall_pct;
  bit hold_req;
  int hold_left;

  particle_euler_integrator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_step_time(in_step_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_acc_x(out_acc_x), .out_acc_y(out_acc_y), .out_acc_z(out_acc_z),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  particle_euler_integrator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_step_time(in_step_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_acc_x(out_acc_x), .out_acc_y(out_acc_y), .out_acc_z(out_acc_z),
    .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .steps_seen(steps_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= (hold_left > 1) || (hold_req && hold_left == 0) ||
                 ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(input logic [2:0] c, input logic signed [Q_W-1:0] x,
                           input logic signed [Q_W-1:0] y, input logic signed [Q_W-1:0] z,
                           input logic [DT_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_vec_x     <= x;
    in_vec_y     <= y;
    in_vec_z     <= z;
    in_step_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    // registers change only once the block has drained
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [Q_W-1:0] rand_vec();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    if (r < 55) return (r < 50) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 60) return DT_W'($urandom_range(1, 4096));
    return DT_W'($urandom);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 35) send_item(CMD_ADD_FORCE, rand_vec(), rand_vec(), rand_vec(), DT_W'($urandom));
    else if (r < 45) send_item(CMD_SET_ACC, rand_vec(), rand_vec(), rand_vec(),
                               DT_W'($urandom));
    else if (r < 55) send_item(CMD_SET_POS, rand_vec(), rand_vec(), rand_vec(),
                               DT_W'($urandom));
    else if (r < 65) send_item(CMD_SET_VEL, rand_vec(), rand_vec(), rand_vec(),
                               DT_W'($urandom));
    else if (r < 96) send_item(CMD_INTEGRATE, $urandom, $urandom, $urandom, rand_dt());
    else send_item(3'($urandom_range(CMD_INTEGRATE + 1, 7)), $urandom, $urandom, $urandom,
                   DT_W'($urandom));
  endtask

  task automatic random_config();
    int r;
    r = $urandom_range(99);
    if (r < 10) write_reg(CFG_INV_MASS, '0);
    else if (r < 60) write_reg(CFG_INV_MASS, CFG_DATA_W'($urandom_range(1, 32'h0004_0000)));
    else write_reg(CFG_INV_MASS, CFG_DATA_W'($urandom));
    r = $urandom_range(99);
    if (r < 20) write_reg(CFG_DAMPING, CFG_DATA_W'(65536));
    else if (r < 30) write_reg(CFG_DAMPING, CFG_DATA_W'($urandom_range(65537, 131071)));
    else if (r < 35) write_reg(CFG_DAMPING, '0);
    else write_reg(CFG_DAMPING, CFG_DATA_W'($urandom_range(1, 65535)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD_FORCE;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_step_time = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INV_MASS;
    cfg_data = '0;
    send_idle_pct = 7;
    recv_stall_pct = 67;
    hold_req = 1'b0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, saturating sums, extremes, skipped steps
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'hffff);
    send_item(CMD_ADD_FORCE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, '0);
    send_item(CMD_ADD_FORCE, 32'sh7fff_ffff, 32'sh8000_0000, -32'sh0001_0000, '0);
    send_item(CMD_SET_POS, 32'sh7fff_ffff, 32'sh8000_0000, '0, '0);
    send_item(CMD_SET_VEL, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0002_0000, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'hffff);
    send_item(CMD_SET_ACC, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_8000, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'd1);
    for (int c = CMD_INTEGRATE + 1; c <= 7; c++) begin
      send_item(3'(c), $urandom, $urandom, $urandom, '1);
    end
    write_reg(CFG_INV_MASS, '0);
    send_item(CMD_ADD_FORCE, 32'sh0001_0000, '0, '0, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'h8000);
    write_reg(CFG_INV_MASS, 31'h7fff_ffff);
    write_reg(CFG_DAMPING, CFG_DATA_W'(17'h1ffff));
    send_item(CMD_SET_VEL, 32'sh0010_0000, -32'sh0010_0000, 32'sh0000_0001, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'h4000);
    write_reg(CFG_DAMPING, '0);
    send_item(CMD_SET_VEL, 32'sh0010_0000, -32'sh0010_0000, 32'sh0000_0001, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'h4000);
    write_reg(CFG_DAMPING, CFG_DATA_W'(1));
    send_item(CMD_SET_VEL, 32'sh0010_0000, -32'sh0010_0000, 32'sh0010_0000, '0);
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'hffff);
    write_reg(CFG_DAMPING, CFG_DATA_W'(32768));
    send_item(CMD_INTEGRATE, '0, '0, '0, 16'h1000);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 67 : 0;
      recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 7 : 0;
      for (int n = 0; n < 400; n++) begin
        if (n % 100 == 0) random_config();
        if (ph == 2 && n == 200) hold_req = 1'b1;
        if (ph == 2 && n == 230) hold_req = 1'b0;
        random_item();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d results, %0d of them from effective integrate steps,",
             results_seen, steps_seen);
    $display("over three stall mixes with register changes between runs");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== particle_euler_integrator.f =====
+incdir+hdl
hdl/pei_pkg.sv
hdl/pei_dp.sv
hdl/pei_ctrl.sv
hdl/particle_euler_integrator.sv
tb/particle_euler_integrator_checker.sv
tb/particle_euler_integrator_tb.sv
